// ===== hw/rtl/round_robin_ema_averager_defines.svh =====
// Assertion helpers shared by the averager RTL.
`ifndef ROUND_ROBIN_EMA_AVERAGER_DEFINES_SVH
`define ROUND_ROBIN_EMA_AVERAGER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define RREMA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define RREMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rrema_pkg.sv =====
package rrema_pkg;

  localparam int NUM_SLOTS    = 4;
  localparam int SLOT_BITS    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int NUM_MUX      = 4;

  localparam int SAMPLE_W     = 10;
  localparam int FRAC_W       = 8;
  localparam int AVG_W        = SAMPLE_W + FRAC_W;
  localparam int ACC_W        = 48;
  localparam int WEIGHT_W     = 9;
  localparam int MUX_W        = 8;
  localparam int SLOT_OUT_W   = 2;
  localparam int PROD_W       = AVG_W + WEIGHT_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = WEIGHT_W;

  typedef logic [SAMPLE_W-1:0]   sample_t;
  typedef logic [AVG_W-1:0]      avg_t;
  typedef logic [ACC_W-1:0]      acc_t;
  typedef logic [WEIGHT_W-1:0]   weight_t;
  typedef logic [MUX_W-1:0]      mux_t;
  typedef logic [SLOT_BITS-1:0]  slot_t;
  typedef logic [SLOT_OUT_W-1:0] slot_out_t;

  localparam acc_t    ACC_MAX        = '1;
  localparam weight_t WEIGHT_FULL    = weight_t'(1 << FRAC_W);
  localparam weight_t WEIGHT_DEFAULT = weight_t'(51);
  localparam slot_t   SLOT_LAST      = slot_t'(NUM_SLOTS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMA_WEIGHT = 3'd0,
    REG_MUX_CODE_A = 3'd1,
    REG_MUX_CODE_B = 3'd2,
    REG_MUX_CODE_C = 3'd3,
    REG_MUX_CODE_D = 3'd4
  } cfg_reg_t;

  // Low two bits of a slot number: selects the mux code and the reported slot.
  function automatic slot_out_t slot_low(slot_t s);
    logic [SLOT_BITS+SLOT_OUT_W-1:0] ext;
    ext = {{SLOT_OUT_W{1'b0}}, s};
    return ext[SLOT_OUT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/rrema_if.sv =====
interface rrema_in_if;
  import rrema_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rrema_out_if;
  import rrema_pkg::*;
  logic      valid;
  logic      ready;
  slot_out_t slot;
  sample_t   sample_echo;
  avg_t      average;
  acc_t      accumulated;
  mux_t      next_mux;

  modport source (output valid, output slot, output sample_echo, output average,
                  output accumulated, output next_mux, input ready);
  modport sink   (input valid, input slot, input sample_echo, input average,
                  input accumulated, input next_mux, output ready);
endinterface

// ===== hw/rtl/rrema_calc.sv =====
module rrema_calc (
  input  rrema_pkg::weight_t weight,
  input  rrema_pkg::sample_t sample,
  input  rrema_pkg::avg_t    avg_old,
  input  rrema_pkg::acc_t    sum_old,
  output rrema_pkg::avg_t    avg_new,
  output rrema_pkg::acc_t    sum_new
);
  import rrema_pkg::*;

  weight_t           w_eff;
  weight_t           w_inv;
  avg_t              sample_q;
  logic [PROD_W-1:0] prod_old;
  logic [PROD_W-1:0] prod_new;
  logic [PROD_W:0]   mix;
  logic [ACC_W:0]    sum_wide;

  // Clamp weights above full scale to full scale.
  assign w_eff    = weight[WEIGHT_W-1] ? WEIGHT_FULL : weight;
  assign w_inv    = WEIGHT_FULL - w_eff;
  assign sample_q = {sample, {FRAC_W{1'b0}}};

  assign prod_old = {{WEIGHT_W{1'b0}}, avg_old} * {{AVG_W{1'b0}}, w_inv};
  assign prod_new = {{WEIGHT_W{1'b0}}, sample_q} * {{AVG_W{1'b0}}, w_eff};
  assign mix      = {1'b0, prod_old} + {1'b0, prod_new};
  assign avg_new  = mix[FRAC_W +: AVG_W];

  // Saturate the running sum at full scale.
  assign sum_wide = {1'b0, sum_old} + {{(ACC_W+1-AVG_W){1'b0}}, avg_new};
  assign sum_new  = sum_wide[ACC_W] ? ACC_MAX : sum_wide[ACC_W-1:0];

endmodule

// ===== hw/rtl/round_robin_ema_averager.sv =====
// Round-robin exponential moving average over four converter slots.
// in_stream (valid/ready) carries one 10-bit raw sample per transfer. Samples
// are assigned to slots 0,1,2,3,0,... in arrival order. For that slot the
// block updates avg = (avg*(256-w) + sample*256*w) >> 8 in Q10.8 and adds the
// new average to a 48-bit saturating accumulator.
// out_stream (valid/ready) returns slot, sample_echo, average, accumulated and
// next_mux, the mux code to select for the following conversion.
// A transferred sample enters the input register; its result is then loaded
// into the result register. Throughput: one sample per cycle unless the
// receiver stalls; the path is one input register, two narrow multipliers
// plus the 48-bit add, and the result register. When the receiver stalls,
// the result register holds; one more sample is still taken into the input
// register, after which in_stream.ready drops until the result is transferred.
// cfg_we/cfg_index/cfg_wdata write ema_weight (index 0) and mux codes A..D (index 1..4); other indexes are ignored.
// The user must write them only while the block is idle; the block itself does not enforce this.
// Synchronous reset (rst_n low) empties both registers, restarts at slot 0,
// clears all averages and accumulators, sets weight 51 and mux codes 0.
`include "round_robin_ema_averager_defines.svh"

module round_robin_ema_averager (
  input  logic                   clk,
  input  logic                   rst_n,
  rrema_in_if.sink               in_stream,
  rrema_out_if.source            out_stream,
  input  logic                   cfg_we,
  input  logic [rrema_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrema_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rrema_pkg::*;

  // Configuration registers
  weight_t   weight_r, weight_nxt;
  mux_t      mux_code_r   [NUM_MUX];
  mux_t      mux_code_nxt [NUM_MUX];

  // Slot pointer, advanced on every input transfer
  slot_t     slot_idx_r, slot_idx_nxt;

  // Input register stage
  logic      stg_vld_r, stg_vld_nxt;
  sample_t   stg_sample_r;
  slot_t     stg_slot_r;

  // Per-slot state
  avg_t      avg_store_r [NUM_SLOTS];
  acc_t      sum_store_r [NUM_SLOTS];

  // Result register
  logic      out_vld_r, out_vld_nxt;
  slot_out_t out_slot_r;
  sample_t   out_sample_r;
  avg_t      out_avg_r;
  acc_t      out_acc_r;
  mux_t      out_mux_r;

  logic      advance;
  logic      compute;
  logic      in_rdy;
  logic      in_xfer;
  avg_t      avg_old;
  acc_t      sum_old;
  avg_t      avg_new;
  acc_t      sum_new;

  // The result register frees up when empty or when its result transfers;
  // the input register frees up when empty or when it moves forward.
  assign advance = !out_vld_r || out_stream.ready;
  assign compute = stg_vld_r && advance;
  assign in_rdy  = !stg_vld_r || advance;
  assign in_xfer = in_stream.valid && in_rdy;

  assign in_stream.ready = in_rdy;

  // Round robin always moves to a different slot, and a slot's state is
  // written in the same cycle the item leaves the input register, so a later
  // item for the same slot always reads the updated value.
  assign avg_old = avg_store_r[stg_slot_r];
  assign sum_old = sum_store_r[stg_slot_r];

  rrema_calc u_calc (
    .weight  (weight_r),
    .sample  (stg_sample_r),
    .avg_old (avg_old),
    .sum_old (sum_old),
    .avg_new (avg_new),
    .sum_new (sum_new)
  );

  // Configuration writes
  always_comb begin
    weight_nxt   = weight_r;
    mux_code_nxt = mux_code_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_EMA_WEIGHT: weight_nxt      = weight_t'(cfg_wdata);
        REG_MUX_CODE_A: mux_code_nxt[0] = cfg_wdata[MUX_W-1:0];
        REG_MUX_CODE_B: mux_code_nxt[1] = cfg_wdata[MUX_W-1:0];
        REG_MUX_CODE_C: mux_code_nxt[2] = cfg_wdata[MUX_W-1:0];
        REG_MUX_CODE_D: mux_code_nxt[3] = cfg_wdata[MUX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= WEIGHT_DEFAULT;
      for (int k = 0; k < NUM_MUX; k++) begin
        mux_code_r[k] <= '0;
      end
    end else begin
      weight_r   <= weight_nxt;
      mux_code_r <= mux_code_nxt;
    end
  end

  // Control next state
  always_comb begin
    slot_idx_nxt = slot_idx_r;
    if (in_xfer) begin
      slot_idx_nxt = (slot_idx_r == SLOT_LAST) ? '0 : slot_idx_r + slot_t'(1);
    end

    stg_vld_nxt = stg_vld_r;
    if (in_xfer) begin
      stg_vld_nxt = 1'b1;
    end else if (compute) begin
      stg_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (compute) begin
      out_vld_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_idx_r <= '0;
      stg_vld_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      slot_idx_r <= slot_idx_nxt;
      stg_vld_r  <= stg_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  // Capture the sample and its slot on transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      stg_sample_r <= in_stream.sample;
      stg_slot_r   <= slot_idx_r;
    end
  end

  // Per-slot averages and sums: cleared by reset, written as the item retires
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
        avg_store_r[k] <= '0;
        sum_store_r[k] <= '0;
      end
    end else if (compute) begin
      avg_store_r[stg_slot_r] <= avg_new;
      sum_store_r[stg_slot_r] <= sum_new;
    end
  end

  // Load the result register; hold it while the receiver stalls
  always_ff @(posedge clk) begin
    if (compute) begin
      out_slot_r   <= slot_low(stg_slot_r);
      out_sample_r <= stg_sample_r;
      out_avg_r    <= avg_new;
      out_acc_r    <= sum_new;
      out_mux_r    <= mux_code_r[slot_low(stg_slot_r)];
    end
  end

  assign out_stream.valid       = out_vld_r;
  assign out_stream.slot        = out_slot_r;
  assign out_stream.sample_echo = out_sample_r;
  assign out_stream.average     = out_avg_r;
  assign out_stream.accumulated = out_acc_r;
  assign out_stream.next_mux    = out_mux_r;

  // Never overwrite a result the receiver has not taken.
  `RREMA_ASSERT_NOW(a_no_overwrite, out_vld_r && !out_stream.ready, !compute,
    "result register overwritten while stalled")

  // An empty input register always accepts.
  `RREMA_ASSERT_NOW(a_ready_when_empty, !stg_vld_r, in_rdy,
    "input register empty but not ready")

  // The new average lies between the old average and the scaled sample.
  `RREMA_ASSERT_NOW(a_avg_bounded, compute,
    (avg_new <= avg_old || avg_new <= {stg_sample_r, {FRAC_W{1'b0}}}) &&
    (avg_new >= avg_old || avg_new >= {stg_sample_r, {FRAC_W{1'b0}}}),
    "average left the range of old average and sample")

  // Accumulators never decrease.
  `RREMA_ASSERT_NEXT(a_sum_monotonic, compute,
    out_acc_r >= $past(sum_old),
    "accumulator decreased")

endmodule

// ===== tb/rrema_tb_pkg.sv =====
package rrema_tb_pkg;
  import rrema_pkg::*;

  typedef struct packed {
    slot_out_t slot;
    sample_t   sample_echo;
    avg_t      average;
    acc_t      accumulated;
    mux_t      next_mux;
  } ema_report_t;

  localparam int MAX_REPORTED = 10;

  // Tracks the per-slot averages and sums, and queues the report each sample should yield.
  class ema_scoreboard;
    weight_t     weight;
    mux_t        mux_code [NUM_MUX];
    avg_t        avg_of [NUM_SLOTS];
    acc_t        sum_of [NUM_SLOTS];
    slot_t       next_slot;
    ema_report_t expected_reports [$];
    int          errors;

    function new();
      weight = WEIGHT_DEFAULT;
      foreach (mux_code[k]) mux_code[k] = '0;
      foreach (avg_of[k]) avg_of[k] = '0;
      foreach (sum_of[k]) sum_of[k] = '0;
      next_slot = '0;
      errors = 0;
    endfunction

    function void log_error(string what);
      errors++;
      if (errors <= MAX_REPORTED) $display("ERROR: %s", what);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        REG_EMA_WEIGHT: weight = data;
        REG_MUX_CODE_A: mux_code[0] = data[MUX_W-1:0];
        REG_MUX_CODE_B: mux_code[1] = data[MUX_W-1:0];
        REG_MUX_CODE_C: mux_code[2] = data[MUX_W-1:0];
        REG_MUX_CODE_D: mux_code[3] = data[MUX_W-1:0];
        default: ;
      endcase
    endfunction

    // Blend the sample into its slot's average, then add to the saturating sum.
    function void note_sample(sample_t s);
      weight_t     w;
      logic [63:0] blend;
      logic [63:0] total;
      ema_report_t r;
      w = (weight > WEIGHT_FULL) ? WEIGHT_FULL : weight;
      blend = (64'(avg_of[next_slot]) * (64'(WEIGHT_FULL) - 64'(w))
               + (64'(s) << FRAC_W) * 64'(w)) >> FRAC_W;
      avg_of[next_slot] = avg_t'(blend);
      total = 64'(sum_of[next_slot]) + 64'(avg_of[next_slot]);
      sum_of[next_slot] = (total > 64'(ACC_MAX)) ? ACC_MAX : acc_t'(total);
      r.slot        = slot_out_t'(next_slot);
      r.sample_echo = s;
      r.average     = avg_of[next_slot];
      r.accumulated = sum_of[next_slot];
      r.next_mux    = mux_code[next_slot % NUM_MUX];
      expected_reports.push_back(r);
      next_slot = (next_slot == SLOT_LAST) ? slot_t'(0) : slot_t'(next_slot + 1);
    endfunction

    function void check_result(slot_out_t slot, sample_t echo, avg_t average, acc_t acc,
                               mux_t mux);
      ema_report_t want;
      if (expected_reports.size() == 0) begin
        log_error($sformatf("unexpected result slot %0d sample %0d", slot, echo));
        return;
      end
      want = expected_reports.pop_front();
      if (slot !== want.slot || echo !== want.sample_echo || average !== want.average ||
          acc !== want.accumulated || mux !== want.next_mux)
        log_error($sformatf({"result mismatch: slot %0d/%0d sample %0d/%0d avg %h/%h ",
                             "acc %h/%h mux %h/%h (expected/actual)"},
                            want.slot, slot, want.sample_echo, echo, want.average, average,
                            want.accumulated, acc, want.next_mux, mux));
    endfunction

    function int open_count();
      return expected_reports.size();
    endfunction

    function void close_out();
      if (expected_reports.size() != 0)
        log_error($sformatf("%0d results never arrived", expected_reports.size()));
    endfunction
  endclass

endpackage

// ===== tb/tb_round_robin_ema_averager.sv =====
module tb_round_robin_ema_averager;
  import rrema_pkg::*;
  import rrema_tb_pkg::*;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 8;
  localparam int TIMEOUT       = 400000 * 2 * HALF_PERIOD;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam int LONG_HOLD     = 80;
  localparam int SETTLE_CYCLES = 2;
  localparam int DRAIN_LIMIT   = 2000;
  localparam int CFG_INDEX_TOP = (1 << CFG_IDX_W) - 1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  rrema_in_if  in_if ();
  rrema_out_if out_if ();

  ema_scoreboard sb = new();

  // Receiver controls: rx_quiet turns off random stalls, rx_hold requests a long hold-off.
  bit tx_gaps;
  bit rx_quiet;
  int rx_hold;

  always #HALF_PERIOD clk = ~clk;

  round_robin_ema_averager i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Hard stop in case the block hangs.
  initial begin
    #(TIMEOUT);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stall bursts of random length, plus a long hold when requested.
  initial begin
    int stall_left;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (!rx_quiet && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 5) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Check every result transfer against the oldest expected report.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.slot, out_if.sample_echo, out_if.average, out_if.accumulated,
                      out_if.next_mux);
  end

  // Offer one sample, optionally after an idle burst, and hold it until the transfer.
  task automatic send_sample(input sample_t s);
    int gap;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(s);
  endtask

  // Drop valid and wait until every expected result has been transferred.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (sb.open_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(index, data);
  endtask

  // Reprogram all registers once idle; also poke an unmapped index, which must be dropped.
  task automatic program_regs(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] a,
                              input logic [CFG_DATA_W-1:0] b, input logic [CFG_DATA_W-1:0] c,
                              input logic [CFG_DATA_W-1:0] d);
    wait_idle();
    write_reg(REG_EMA_WEIGHT, w);
    write_reg(REG_MUX_CODE_A, a);
    write_reg(REG_MUX_CODE_B, b);
    write_reg(REG_MUX_CODE_C, c);
    write_reg(REG_MUX_CODE_D, d);
    write_reg(CFG_IDX_W'($urandom_range(REG_MUX_CODE_D + 1, CFG_INDEX_TOP)),
              CFG_DATA_W'($urandom_range(0, 511)));
    cfg_we <= 1'b0;
  endtask

  // Skew toward the rails and narrow bands near them; full range otherwise.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return sample_t'($urandom_range(0, 15));
      3:       return sample_t'($urandom_range(1008, 1023));
      default: return sample_t'($urandom_range(0, 1023));
    endcase
  endfunction

  // Weights include zero, unity, default, full, and values above full (clamped).
  function automatic logic [CFG_DATA_W-1:0] pick_weight();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return 9'd1;
      2:       return WEIGHT_DEFAULT;
      3:       return WEIGHT_FULL;
      4:       return '1;
      5:       return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  initial begin
    int guard;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_EMA_WEIGHT;
    cfg_wdata    <= '0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    tx_gaps  = 1'b1;
    rx_quiet = 1'b0;
    rx_hold  = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default weight, zero mux codes: rails on every slot, then alternating bit patterns.
    send_sample('0);
    repeat (5) send_sample('1);
    send_sample(10'h2AA);
    send_sample(10'h155);

    // Full weight: average tracks the sample exactly. Bit 8 on a mux write is dropped.
    program_regs(WEIGHT_FULL, 9'h1FF, 9'h000, 9'h0A5, 9'h15A);
    send_sample('0);
    send_sample('1);
    send_sample(10'h200);
    send_sample(10'h001);

    // Zero weight: every average holds its old value.
    program_regs('0, 9'h0FF, 9'h180, 9'h05A, 9'h0C3);
    send_sample('1);
    send_sample('1);
    send_sample('0);
    send_sample(10'h3FE);

    // Weights above full clamp to full.
    program_regs('1, 9'h011, 9'h022, 9'h044, 9'h088);
    send_sample(10'h3C3);
    send_sample(10'h03C);
    send_sample('1);
    send_sample('0);
    program_regs(9'd257, 9'h100, 9'h1FF, 9'h07E, 9'h081);
    send_sample(10'h155);
    send_sample(10'h2AA);

    for (int p = 0; p < PHASES; p++) begin
      program_regs(pick_weight(), CFG_DATA_W'($urandom_range(0, 511)),
                   CFG_DATA_W'($urandom_range(0, 511)), CFG_DATA_W'($urandom_range(0, 511)),
                   CFG_DATA_W'($urandom_range(0, 511)));
      tx_gaps = 1'b1;
      if (p == 3) begin
        // Hold the receiver off while samples keep coming so the block backs up.
        tx_gaps = 1'b0;
        rx_hold = LONG_HOLD;
      end
      if (p == PHASES - 1) begin
        // Close with back-to-back transfers on both sides.
        tx_gaps  = 1'b0;
        rx_quiet = 1'b1;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 5 && i == PHASE_ITEMS / 2) begin
          // Pause the sender until everything in flight has come out.
          in_if.valid <= 1'b0;
          while (sb.open_count() != 0) @(posedge clk);
        end
        send_sample(pick_sample());
      end
    end

    // Drain, then let a stray result still show up before the final check.
    in_if.valid <= 1'b0;
    guard = 0;
    while (sb.open_count() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rrema_pkg.sv
hw/rtl/rrema_if.sv
hw/rtl/rrema_calc.sv
hw/rtl/round_robin_ema_averager.sv
tb/rrema_tb_pkg.sv
tb/tb_round_robin_ema_averager.sv
